// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros for the console writer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked from one edge to the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ROWS        = 25;
  localparam int COLS        = 80;
  localparam int SCREEN_SIZE = ROWS * COLS;

  localparam int ADDR_W = $clog2(SCREEN_SIZE);
  localparam int CUR_W  = $clog2(SCREEN_SIZE + COLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int IDX_W  = $clog2(SCREEN_SIZE + 1);

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;
  localparam int RADDR_W = 11;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam int                TAB_STEP     = 8;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_POST,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              put;
    logic              scroll;
    logic [CHAR_W-1:0] code;
  } cur_ctl_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic             past_end;
  } cur_stat_t;

endpackage

// ===== hdl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// 80x25 text screen store with a cursor, fed by put and read commands.
// ----------------------------------------------------------------------------
// Each command returns one result carrying the cursor after the command and,
// for a read, the addressed cell (attribute high byte, character low byte;
// zero for a put or an out-of-range read). A put or a read is walked through
// the cell memory by the sequencer, and a new command is accepted only once
// the result of the last one has been loaded into the output register. A put
// that runs the cursor past the last cell scrolls the screen by copying every
// cell up one row and blanking the last row, one cell per cycle, using the
// memory's read and write ports side by side. After reset the block clears all
// ROWS*COLS cells and holds in_stall high until that pass is done.
module text_console_writer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]   in_attribute,
  input  logic [tcw_pkg::RADDR_W-1:0]  in_read_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_value
);

  tcw_pkg::state_t state_r, state_nxt;

  logic [tcw_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        cmd_r;
  logic [tcw_pkg::CHAR_W-1:0]  code_r;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic [tcw_pkg::RADDR_W-1:0] raddr_r;
  logic [tcw_pkg::CELL_W-1:0]  value_r, value_nxt;
  logic                        out_valid_r;
  logic [tcw_pkg::POS_W-1:0]   out_cursor_r;
  logic [tcw_pkg::CELL_W-1:0]  out_value_r;

  logic [tcw_pkg::CELL_W-1:0]  mem [tcw_pkg::SCREEN_SIZE];
  logic [tcw_pkg::CELL_W-1:0]  rd_data_r;
  logic                        mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0]  mem_wa, mem_ra;
  logic [tcw_pkg::CELL_W-1:0]  mem_wd;

  tcw_pkg::cur_ctl_t  cur_ctl;
  tcw_pkg::cur_stat_t cur_stat;

  logic                        in_accept, out_free, out_load, addr_ok;
  logic [tcw_pkg::ATTR_W-1:0]  attr_eff;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != tcw_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign addr_ok   = (int'(raddr_r) < tcw_pkg::SCREEN_SIZE);
  assign attr_eff  = (attr_r == '0) ? tcw_pkg::DEFAULT_ATTR : attr_r;

  tcw_cursor u_cursor (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (cur_ctl),
    .stat (cur_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        if (idx_r == tcw_pkg::IDX_W'(tcw_pkg::SCREEN_SIZE - 1)) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        state_nxt = (cmd_r == tcw_pkg::CMD_READ) ? tcw_pkg::ST_RDWAIT : tcw_pkg::ST_POST;
      end
      tcw_pkg::ST_RDWAIT: state_nxt = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_POST: begin
        state_nxt = cur_stat.past_end ? tcw_pkg::ST_COPY : tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_COPY: begin
        if (idx_r == tcw_pkg::IDX_W'(tcw_pkg::SCREEN_SIZE - tcw_pkg::COLS)) begin
          state_nxt = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_BLANK: begin
        if (idx_r == tcw_pkg::IDX_W'(tcw_pkg::SCREEN_SIZE - 1)) state_nxt = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_FINISH: begin
        if (out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    idx_nxt   = idx_r;
    value_nxt = value_r;
    cur_ctl   = '0;
    out_load  = 1'b0;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r[tcw_pkg::ADDR_W-1:0];
        mem_wd  = tcw_pkg::BLANK_CELL;
        idx_nxt = idx_r + tcw_pkg::IDX_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        idx_nxt = '0;
      end
      tcw_pkg::ST_EXEC: begin
        value_nxt = '0;
        if (cmd_r == tcw_pkg::CMD_READ) begin
          mem_re = addr_ok;
          mem_ra = tcw_pkg::ADDR_W'(raddr_r);
        end else begin
          cur_ctl.put  = 1'b1;
          cur_ctl.code = code_r;
          // Backspace blanks the cell it steps back onto; tab, line feed and carriage return write nothing.
          if (code_r == tcw_pkg::CH_BS) begin
            mem_we = (cur_stat.cursor != '0);
            mem_wa = tcw_pkg::ADDR_W'(cur_stat.cursor - tcw_pkg::CUR_W'(1));
            mem_wd = {attr_eff, tcw_pkg::SPACE_CHAR};
          end else if (code_r != tcw_pkg::CH_TAB && code_r != tcw_pkg::CH_LF &&
                       code_r != tcw_pkg::CH_CR) begin
            mem_we = 1'b1;
            mem_wa = tcw_pkg::ADDR_W'(cur_stat.cursor);
            mem_wd = {attr_eff, code_r};
          end
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        value_nxt = addr_ok ? rd_data_r : '0;
      end
      tcw_pkg::ST_POST: begin
        idx_nxt = '0;
        if (cur_stat.past_end) cur_ctl.scroll = 1'b1;
      end
      tcw_pkg::ST_COPY: begin
        // The read one row below is issued in the cycle before the write it feeds.
        if (idx_r < tcw_pkg::IDX_W'(tcw_pkg::SCREEN_SIZE - tcw_pkg::COLS)) begin
          mem_re  = 1'b1;
          mem_ra  = tcw_pkg::ADDR_W'(idx_r + tcw_pkg::IDX_W'(tcw_pkg::COLS));
          idx_nxt = idx_r + tcw_pkg::IDX_W'(1);
        end
        if (idx_r != '0) begin
          mem_we = 1'b1;
          mem_wa = tcw_pkg::ADDR_W'(idx_r - tcw_pkg::IDX_W'(1));
          mem_wd = rd_data_r;
        end
      end
      tcw_pkg::ST_BLANK: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r[tcw_pkg::ADDR_W-1:0];
        mem_wd  = tcw_pkg::BLANK_CELL;
        idx_nxt = idx_r + tcw_pkg::IDX_W'(1);
      end
      tcw_pkg::ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (in_accept) begin
      cmd_r   <= in_command;
      code_r  <= in_char_code;
      attr_r  <= in_attribute;
      raddr_r <= in_read_address;
    end
    if (out_load) begin
      out_cursor_r <= tcw_pkg::POS_W'(cur_stat.cursor);
      out_value_r  <= value_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_cell_value      = out_value_r;

endmodule

// ===== hdl/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor register with its column, stepped by put commands and scrolls.
// ----------------------------------------------------------------------------
module tcw_cursor (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::cur_ctl_t  ctl,
  output tcw_pkg::cur_stat_t stat
);

  logic [tcw_pkg::CUR_W-1:0]   cursor_r, cursor_nxt;
  logic [tcw_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [tcw_pkg::COL_W:0]     col_inc, col_tab;

  // The column is tracked alongside the cursor so that row starts need no division.
  always_comb begin
    col_inc = (tcw_pkg::COL_W+1)'(col_r) + (tcw_pkg::COL_W+1)'(1);
    if (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLS)) begin
      col_inc = col_inc - (tcw_pkg::COL_W+1)'(tcw_pkg::COLS);
    end
    col_tab = (tcw_pkg::COL_W+1)'(col_r) + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STEP);
    if (col_tab >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLS)) begin
      col_tab = col_tab - (tcw_pkg::COL_W+1)'(tcw_pkg::COLS);
    end
  end

  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    if (ctl.scroll) begin
      cursor_nxt = cursor_r - tcw_pkg::CUR_W'(tcw_pkg::COLS);
    end else if (ctl.put) begin
      unique case (ctl.code)
        tcw_pkg::CH_BS: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - tcw_pkg::CUR_W'(1);
            col_nxt    = (col_r == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLS - 1)
                                       : col_r - tcw_pkg::COL_W'(1);
          end
        end
        tcw_pkg::CH_TAB: begin
          cursor_nxt = cursor_r + tcw_pkg::CUR_W'(tcw_pkg::TAB_STEP);
          col_nxt    = col_tab[tcw_pkg::COL_W-1:0];
        end
        tcw_pkg::CH_LF: begin
          cursor_nxt = cursor_r - tcw_pkg::CUR_W'(col_r) + tcw_pkg::CUR_W'(tcw_pkg::COLS);
          col_nxt    = '0;
        end
        tcw_pkg::CH_CR: begin
          cursor_nxt = cursor_r - tcw_pkg::CUR_W'(col_r);
          col_nxt    = '0;
        end
        default: begin
          cursor_nxt = cursor_r + tcw_pkg::CUR_W'(1);
          col_nxt    = col_inc[tcw_pkg::COL_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

  assign stat.cursor   = cursor_r;
  assign stat.past_end = (cursor_r >= tcw_pkg::CUR_W'(tcw_pkg::SCREEN_SIZE));

endmodule

// ===== hdl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_command,
  input logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input logic [tcw_pkg::ATTR_W-1:0]   in_attribute,
  input logic [tcw_pkg::RADDR_W-1:0]  in_read_address,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tcw_pkg::POS_W-1:0]    out_cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]   out_cell_value
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_cursor_position) && $stable(out_cell_value), "stalled result changed")
  `ASSERT_CLK(a_cursor_range, !out_valid || (int'(out_cursor_position) < tcw_pkg::SCREEN_SIZE), "cursor beyond the screen")
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transfer accepted while busy")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 80x25 text console writer. A shadow copy of
// the screen and cursor predicts the result of every accepted command, and
// every result transfer is checked against the oldest prediction. Directed
// commands cover reset contents, the control codes and the edges of the
// address range. Random bursts of text lines, line feeds, tabs, backspaces
// and reads then drive the cursor onto the last row so that scrolling is
// exercised often. Both sides idle at random, the result side also holds
// off for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
  } console_result_t;

  // Shadow of the screen store and cursor, plus the results still owed.
  class screen_shadow;
    logic [CELL_W-1:0] cells [SCREEN_SIZE];
    int unsigned       cur_pos;
    console_result_t   owed_results [$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = BLANK_CELL;
      cur_pos    = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_command(logic cmd, logic [CHAR_W-1:0] code,
                               logic [ATTR_W-1:0] attr, logic [RADDR_W-1:0] addr);
      logic [ATTR_W-1:0] a;
      console_result_t   r;
      r.cell_val = '0;
      if (cmd == CMD_PUT) begin
        a = (attr == '0) ? DEFAULT_ATTR : attr;
        case (code)
          CH_BS: begin
            // Backspace at the first cell leaves everything as it is.
            if (cur_pos > 0) begin
              cur_pos--;
              cells[cur_pos] = {a, SPACE_CHAR};
            end
          end
          CH_TAB: cur_pos += TAB_STEP;
          CH_LF:  cur_pos = (cur_pos / COLS + 1) * COLS;
          CH_CR:  cur_pos = cur_pos - cur_pos % COLS;
          default: begin
            cells[cur_pos] = {a, code};
            cur_pos++;
          end
        endcase
        // Running past the last cell scrolls the whole screen up one row.
        if (cur_pos >= SCREEN_SIZE) begin
          for (int i = 0; i < SCREEN_SIZE - COLS; i++) cells[i] = cells[i + COLS];
          for (int i = SCREEN_SIZE - COLS; i < SCREEN_SIZE; i++) cells[i] = BLANK_CELL;
          cur_pos -= COLS;
        end
      end else if (addr < SCREEN_SIZE) begin
        r.cell_val = cells[addr];
      end
      r.pos = POS_W'(cur_pos);
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic [CELL_W-1:0] cell_val);
      console_result_t e;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, cursor_position %0d cell_value 0x%04h",
                 $time, pos, cell_val);
        mismatches++;
        return;
      end
      e = owed_results.pop_front();
      if (pos !== e.pos) begin
        $display("%0t: cursor_position expected %0d actual %0d", $time, e.pos, pos);
        mismatches++;
      end
      if (cell_val !== e.cell_val) begin
        $display("%0t: cell_value expected 0x%04h actual 0x%04h", $time, e.cell_val,
                 cell_val);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_command = CMD_PUT;
  logic [CHAR_W-1:0]   in_char_code = '0;
  logic [ATTR_W-1:0]   in_attribute = '0;
  logic [RADDR_W-1:0]  in_read_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [POS_W-1:0]    out_cursor_position;
  logic [CELL_W-1:0]   out_cell_value;

  screen_shadow shadow = new();

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_req = 0;
  int items_sent = 0;

  text_console_writer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_char_code        (in_char_code),
    .in_attribute        (in_attribute),
    .in_read_address     (in_read_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        shadow.note_command(in_command, in_char_code, in_attribute, in_read_address);
      if (out_valid && !out_stall)
        shadow.check_result(out_cursor_position, out_cell_value);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(logic cmd, logic [CHAR_W-1:0] code,
                              logic [ATTR_W-1:0] attr, logic [RADDR_W-1:0] addr);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_command      = cmd;
    in_char_code    = code;
    in_attribute    = attr;
    in_read_address = addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_put(logic [CHAR_W-1:0] code, logic [ATTR_W-1:0] attr);
    send_command(CMD_PUT, code, attr, RADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic send_read(logic [RADDR_W-1:0] addr);
    send_command(CMD_READ, CHAR_W'($urandom), ATTR_W'($urandom), addr);
  endtask

  function automatic logic [ATTR_W-1:0] rand_attr();
    if ($urandom_range(0, 4) == 0) return '0;
    return ATTR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [RADDR_W-1:0] rand_read_addr();
    int p;
    int lo;
    int hi;
    p  = $urandom_range(0, 99);
    lo = (shadow.cur_pos > 8) ? shadow.cur_pos - 8 : 0;
    hi = (shadow.cur_pos + 8 > SCREEN_SIZE - 1) ? SCREEN_SIZE - 1 : shadow.cur_pos + 8;
    if (p < 50) return RADDR_W'($urandom_range(0, SCREEN_SIZE - 1));
    if (p < 75) return RADDR_W'($urandom_range(lo, hi));
    if (p < 85) return RADDR_W'($urandom_range(SCREEN_SIZE - COLS, SCREEN_SIZE - 1));
    return RADDR_W'($urandom_range(0, 2047));
  endfunction

  // Result side: a random hold-off before each transfer, or a long one on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        out_stall = 1'b1;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end
      n = rx_idle_en ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int       kind;
    int       len;
    int       pick;
    logic [1:0] idle_mode;
    bit       hold_done;
    bit       pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset contents and the address range edges, including out of range.
    send_read(RADDR_W'(0));
    send_read(RADDR_W'(SCREEN_SIZE - 1));
    send_read(RADDR_W'(SCREEN_SIZE));
    send_read(RADDR_W'(2047));
    send_put(CH_BS, 8'h00);
    send_put(8'h41, 8'h00);
    send_put(8'hFF, 8'hFF);
    send_put(8'h00, 8'h80);
    send_put(CH_BS, 8'h4E);
    send_read(RADDR_W'(1));
    send_read(RADDR_W'(2));
    send_put(CH_TAB, 8'h12);
    send_put(CH_CR, 8'h00);
    send_put(CH_LF, 8'h00);
    send_read(RADDR_W'(0));
    send_put(8'h78, 8'h01);
    send_put(CH_CR, 8'h33);
    send_read(RADDR_W'(COLS));

    while (items_sent < 400) begin
      if ($urandom_range(0, 7) == 0) begin
        idle_mode  = 2'($urandom_range(0, 3));
        tx_idle_en = idle_mode[0];
        rx_idle_en = idle_mode[1];
      end
      // Stall the result side for a long time while commands keep coming.
      if (!hold_done && items_sent >= 150) begin
        tx_idle_en  = 1'b0;
        rx_hold_req = 200;
        hold_done   = 1'b1;
      end
      if (!pause_done && items_sent >= 280) begin
        in_valid = 1'b0;
        while (shadow.pending() != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(0, 15);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 85)      send_put(CHAR_W'($urandom_range(8'h20, 8'h7E)), rand_attr());
          else if (pick < 95) send_put(CHAR_W'($urandom_range(0, 255)), rand_attr());
          else                send_put(CH_TAB, rand_attr());
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_put(CH_LF, rand_attr());
        end else if (pick < 85) begin
          send_put(CH_CR, rand_attr());
          send_put(CH_LF, rand_attr());
        end
      end else if (kind < 60) begin
        repeat ($urandom_range(3, 15)) send_put(CH_LF, rand_attr());
      end else if (kind < 70) begin
        repeat ($urandom_range(2, 12)) send_put(CH_TAB, rand_attr());
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) send_put(CH_BS, rand_attr());
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 4)) send_read(rand_read_addr());
      end else begin
        repeat ($urandom_range(1, 4))
          send_command(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                       ATTR_W'($urandom_range(0, 255)), RADDR_W'($urandom_range(0, 2047)));
      end
    end

    in_valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
